// File: sv/lcsp_pkg.sv
// Shared constants and saturating add/subtract functions for the size-limited LRU cache tracker.
package lcsp_pkg;
    localparam int MAX_ENTRIES_DEF = 30;
    localparam int KEY_W  = 32;
    localparam int SIZE_W = 32;
    localparam int TOT_W  = 48;
    localparam int KIND_W = 3;
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_PRUNE  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_HIT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MISS    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADD_EV  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PRUNED  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PRUNE_0 = 3'd5;

    localparam int REG_TOTAL_CAP = 0;
    localparam int REG_DEAD_CAP  = 1;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
    endfunction

    function automatic logic [TOT_W-1:0] sat_sub(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction
endpackage

// File: sv/lcsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module lcsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/lru_cache_size_pruning.sv
// Size-limited LRU cache tracker: entries held as a circular list in RAM.
// Usage:
//   s_axis carries one request word: key and size in tdata, action (lookup,
//   add, prune) in tuser. m_axis returns one or more result words per lookup,
//   add or prune request with the kind in tuser; m_axis_tlast marks the final
//   one. APB writes and reads back total_capacity (0x0) and dead_capacity (0x8).
// Entries live in one RAM of key/size pairs arranged as a ring: the head
// pointer names the least recent entry, so eviction only advances the head.
// Sequencing:
//   add: reads the oldest slot, then writes the new entry at the tail,
//   evicting the oldest when the list is full. lookup: compares entries
//   from the head in turn; a hit moves the younger entries down one slot,
//   each with a read and a write, and puts the hit entry at the tail.
//   prune: evicts from the head one entry at a time, one result word each.
//   One request is in work at a time.
// Reset empties the list and clears both totals and both capacities.
// When m_axis_tready is low the block holds the pending result word and
// stops; s_axis_tready stays low until the last result word is taken.
module lru_cache_size_pruning #(
    parameter int MAX_ENTRIES = lcsp_pkg::MAX_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // key[31:0], entry_size[63:32]
    input  logic [1:0]   s_axis_tuser,   // action[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // out_key[31:0], out_size[63:32],
                                         // live_total[111:64], dead_total[159:112]
    output logic [2:0]   m_axis_tuser,   // kind[2:0]
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = lcsp_pkg::TOT_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
    localparam logic [AW-1:0] IDX_LAST = AW'(MAX_ENTRIES - 1);
    localparam logic [3:0] ADDR_TCAP = 4'(lcsp_pkg::REG_TOTAL_CAP * 8);
    localparam logic [3:0] ADDR_DCAP = 4'(lcsp_pkg::REG_DEAD_CAP * 8);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_SHIFT_RD, ST_SHIFT_WR, ST_PUT_HIT,
        ST_ADD_RD, ST_ADD_WR, ST_PRUNE_CHK, ST_PRUNE_RD, ST_EMIT
    } state_t;

    state_t state_reg;
    logic [TW-1:0] tcap_reg, dcap_reg, live_reg, dead_reg;
    logic [AW-1:0] head_reg, ptr_reg;
    logic [CW-1:0] count_reg, idx_reg;
    logic [31:0]   key_reg, size_reg, hkey_reg, hsize_reg;
    logic          pruned_reg;
    logic [162:0]  mdata_reg;
    logic          mlast_reg, mvalid_reg;
    logic          emit_now, mvalid_next;

    // RAM ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;

    lcsp_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == IDX_LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] h, input logic [CW-1:0] o);
        logic [AW:0] s;
        s = {1'b0, h} + (AW+1)'(o);
        return (s >= (AW+1)'(MAX_ENTRIES)) ? AW'(s - (AW+1)'(MAX_ENTRIES)) : s[AW-1:0];
    endfunction

    logic apb_wr;
    assign apb_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr)
            ADDR_TCAP: prdata = {16'h0, tcap_reg};
            ADDR_DCAP: prdata = {16'h0, dcap_reg};
            default:   prdata = '0;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg[162:3];
    assign m_axis_tuser  = mdata_reg[2:0];
    assign m_axis_tlast  = mlast_reg;

    assign emit_now = (state_reg == ST_PRUNE_RD) ||
                      (state_reg == ST_EMIT && (!mvalid_reg || m_axis_tready));
    assign mvalid_next = emit_now || (mvalid_reg && !m_axis_tready);

    logic [TW-1:0] sum_ld;
    logic          over;
    assign sum_ld = lcsp_pkg::sat_add(live_reg, dead_reg);
    assign over   = (sum_ld > tcap_reg) || (dead_reg > dcap_reg);

    always_comb begin
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = {size_reg, key_reg};
        raddr = ptr_reg;
        unique case (state_reg)
            ST_SHIFT_WR: begin
                we = 1'b1;
                wdata = rdata;
            end
            ST_PUT_HIT: begin
                we = 1'b1;
                wdata = {hsize_reg, hkey_reg};
            end
            ST_ADD_WR: begin
                we = 1'b1;
            end
            ST_SHIFT_RD: raddr = wrap_inc(ptr_reg);
            default: ;
        endcase
    end

    function automatic logic [162:0] pack_out(input logic [2:0] k, input logic [31:0] ky,
                                              input logic [31:0] sz, input logic [TW-1:0] lv,
                                              input logic [TW-1:0] dd);
        return {dd, lv, sz, ky, k};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tcap_reg   <= '0;
            dcap_reg   <= '0;
            live_reg   <= '0;
            dead_reg   <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (apb_wr && paddr == ADDR_TCAP) tcap_reg <= pwdata[TW-1:0];
            if (apb_wr && paddr == ADDR_DCAP) dcap_reg <= pwdata[TW-1:0];
            mvalid_reg <= mvalid_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        key_reg    <= s_axis_tdata[31:0];
                        size_reg   <= s_axis_tdata[63:32];
                        idx_reg    <= '0;
                        ptr_reg    <= head_reg;
                        pruned_reg <= 1'b0;
                        unique case (s_axis_tuser)
                            lcsp_pkg::ACT_LOOKUP: state_reg <= ST_SCAN_RD;
                            lcsp_pkg::ACT_ADD:    state_reg <= ST_ADD_RD;
                            lcsp_pkg::ACT_PRUNE: begin
                                dead_reg  <= '0;
                                state_reg <= ST_PRUNE_CHK;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SCAN_RD: begin
                    if (idx_reg == count_reg) begin
                        mdata_reg <= pack_out(lcsp_pkg::KIND_MISS, '0, '0, live_reg, dead_reg);
                        mlast_reg <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_SCAN_CHK;
                    end
                end
                ST_SCAN_CHK: begin
                    if (rdata[31:0] == key_reg) begin
                        hkey_reg  <= rdata[31:0];
                        hsize_reg <= rdata[63:32];
                        mdata_reg <= pack_out(lcsp_pkg::KIND_HIT, rdata[31:0], rdata[63:32],
                                              live_reg, dead_reg);
                        mlast_reg <= 1'b1;
                        state_reg <= (idx_reg + CW'(1) == count_reg) ? ST_EMIT : ST_SHIFT_RD;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        ptr_reg   <= wrap_inc(ptr_reg);
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_SHIFT_RD: state_reg <= ST_SHIFT_WR;
                ST_SHIFT_WR: begin
                    // slot ptr takes its younger neighbor
                    ptr_reg <= wrap_inc(ptr_reg);
                    idx_reg <= idx_reg + CW'(1);
                    state_reg <= (idx_reg + CW'(2) == count_reg) ? ST_PUT_HIT : ST_SHIFT_RD;
                end
                ST_PUT_HIT: state_reg <= ST_EMIT;
                ST_ADD_RD: begin
                    // oldest is being read; write goes to the tail slot
                    ptr_reg   <= (count_reg >= CNT_MAX) ? head_reg
                                                        : ring_at(head_reg, count_reg);
                    state_reg <= ST_ADD_WR;
                end
                ST_ADD_WR: begin
                    state_reg <= ST_EMIT;
                    mlast_reg <= 1'b1;
                    if (count_reg >= CNT_MAX) begin
                        // evicted slot is overwritten by the new entry
                        head_reg <= wrap_inc(head_reg);
                        live_reg <= lcsp_pkg::sat_add(
                            lcsp_pkg::sat_sub(live_reg, TW'(rdata[63:32])), TW'(size_reg));
                        dead_reg <= lcsp_pkg::sat_add(dead_reg, TW'(rdata[63:32]));
                        mdata_reg <= pack_out(lcsp_pkg::KIND_ADD_EV, rdata[31:0], rdata[63:32],
                            lcsp_pkg::sat_add(lcsp_pkg::sat_sub(live_reg, TW'(rdata[63:32])),
                                              TW'(size_reg)),
                            lcsp_pkg::sat_add(dead_reg, TW'(rdata[63:32])));
                    end else begin
                        count_reg <= count_reg + CW'(1);
                        live_reg  <= lcsp_pkg::sat_add(live_reg, TW'(size_reg));
                        mdata_reg <= pack_out(lcsp_pkg::KIND_ADDED, '0, '0,
                            lcsp_pkg::sat_add(live_reg, TW'(size_reg)), dead_reg);
                    end
                end
                ST_PRUNE_CHK: begin
                    if (!mvalid_reg || m_axis_tready) begin
                        if (count_reg != '0 && over) begin
                            ptr_reg   <= head_reg;
                            state_reg <= ST_PRUNE_RD;
                        end else if (!pruned_reg) begin
                            mdata_reg <= pack_out(lcsp_pkg::KIND_PRUNE_0, '0, '0,
                                                  live_reg, dead_reg);
                            mlast_reg <= 1'b1;
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_PRUNE_RD: begin
                    // ram data of head now valid: drop it
                    head_reg  <= wrap_inc(head_reg);
                    ptr_reg   <= wrap_inc(head_reg);
                    count_reg <= count_reg - CW'(1);
                    live_reg  <= lcsp_pkg::sat_sub(live_reg, TW'(rdata[63:32]));
                    pruned_reg <= 1'b1;
                    mdata_reg <= pack_out(lcsp_pkg::KIND_PRUNED, rdata[31:0], rdata[63:32],
                        lcsp_pkg::sat_sub(live_reg, TW'(rdata[63:32])), dead_reg);
                    // last if nothing more will be evicted
                    mlast_reg <= (count_reg == CW'(1)) ||
                        !((lcsp_pkg::sat_add(lcsp_pkg::sat_sub(live_reg,
                            TW'(rdata[63:32])), dead_reg) > tcap_reg)
                          || (dead_reg > dcap_reg));
                    state_reg <= ST_PRUNE_CHK;
                end
                ST_EMIT: begin
                    if (!mvalid_reg || m_axis_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: sv/lcsp_checker.sv
// Port-level checks for the LRU cache tracker, bound to the top level.
module lcsp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast,
    input logic         pready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
            $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result word changed under stall");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser <= lcsp_pkg::ACT_PRUNE
            |=> !s_axis_tready)
        else $error("accepted a word while busy");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= lcsp_pkg::KIND_PRUNE_0)
        else $error("bad result kind");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != lcsp_pkg::KIND_PRUNED |-> m_axis_tlast)
        else $error("single result without last");
    a_rdy: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind lru_cache_size_pruning lcsp_checker u_lcsp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast), .pready(pready)
);

// File: dv/lru_cache_size_pruning_test.sv
// Self-checking testbench for the size-limited LRU cache tracker.
`timescale 1ns / 100ps

module lru_cache_size_pruning_test;
    localparam int NENT = lcsp_pkg::MAX_ENTRIES_DEF;
    localparam int TW = lcsp_pkg::TOT_W;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic [31:0] size;
    } req_t;

    typedef struct packed {
        logic [lcsp_pkg::KIND_W-1:0] kind;
        logic [31:0]                 rkey;
        logic [31:0]                 rsize;
        logic [TW-1:0]               live;
        logic [TW-1:0]               dead;
        logic                        last;
    } res_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel, penable, pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    lru_cache_size_pruning dut (.*);

    // predictor state
    logic [31:0]   pk [NENT];
    logic [31:0]   ps [NENT];
    int            pcount;
    logic [TW-1:0] plive, pdead, cap_total, cap_dead;

    req_t pending_reqs[$];
    res_t expected_results[$];

    int  mismatches = 0;
    int  n_results = 0;
    int  n_prunes = 0;
    bit  src_calm = 0, sink_calm = 0, sink_hold = 0;
    bit  hold_go = 0, hold_done = 0;
    int  hold_cnt = 0;
    int  quiet = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [TW-1:0] add48(logic [TW-1:0] a, logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] sub48(logic [TW-1:0] a, logic [TW-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic void push_res(logic [lcsp_pkg::KIND_W-1:0] k, logic [31:0] a,
                                     logic [31:0] b);
        res_t r;
        r = '{k, a, b, plive, pdead, 1'b0};
        expected_results = {expected_results, r};
    endfunction

    function automatic void pop_oldest(output logic [31:0] k, output logic [31:0] s);
        k = pk[0];
        s = ps[0];
        for (int i = 0; i < NENT - 1; i++) begin
            pk[i] = pk[i+1];
            ps[i] = ps[i+1];
        end
        pcount--;
    endfunction

    function automatic void predict(req_t q);
        logic [31:0] ek, es;
        int idx, n;
        ek = '0;
        es = '0;
        idx = -1;
        n = 0;
        case (q.action)
            lcsp_pkg::ACT_LOOKUP: begin
                for (int i = 0; i < pcount; i++)
                    if (idx < 0 && pk[i] == q.key) idx = i;
                if (idx < 0) push_res(lcsp_pkg::KIND_MISS, '0, '0);
                else begin
                    ek = pk[idx];
                    es = ps[idx];
                    for (int i = idx; i < pcount - 1; i++) begin
                        pk[i] = pk[i+1];
                        ps[i] = ps[i+1];
                    end
                    pk[pcount-1] = ek;
                    ps[pcount-1] = es;
                    push_res(lcsp_pkg::KIND_HIT, ek, es);
                end
            end
            lcsp_pkg::ACT_ADD: begin
                if (pcount >= NENT) begin
                    pop_oldest(ek, es);
                    plive = sub48(plive, TW'(es));
                    pdead = add48(pdead, TW'(es));
                    n = 1;
                end
                pk[pcount] = q.key;
                ps[pcount] = q.size;
                pcount++;
                plive = add48(plive, TW'(q.size));
                push_res((n != 0) ? lcsp_pkg::KIND_ADD_EV : lcsp_pkg::KIND_ADDED, ek, es);
            end
            lcsp_pkg::ACT_PRUNE: begin
                n_prunes++;
                pdead = '0;
                while (pcount > 0 &&
                       (add48(plive, pdead) > cap_total || pdead > cap_dead)) begin
                    pop_oldest(ek, es);
                    plive = sub48(plive, TW'(es));
                    push_res(lcsp_pkg::KIND_PRUNED, ek, es);
                    n++;
                end
                if (n == 0) push_res(lcsp_pkg::KIND_PRUNE_0, '0, '0);
            end
            default: return;
        endcase
        expected_results[$].last = 1'b1;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict(pending_reqs.pop_front());
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() > 0 && (src_calm || $urandom_range(99) >= 19)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {pending_reqs[0].size, pending_reqs[0].key};
                    s_axis_tuser  <= pending_reqs[0].action;
                end else s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            if (hold_cnt < HOLD_CYCLES) begin
                sink_hold <= 1'b1;
                hold_cnt  <= hold_cnt + 1;
            end else begin
                sink_hold <= 1'b0;
                hold_done <= 1'b1;
            end
        end
    end

    // monitor and sink
    always @(posedge aclk) begin : mon
        res_t got, exp_r;
        if (!aresetn) m_axis_tready <= 1'b0;
        else begin
            m_axis_tready <= !sink_hold && (sink_calm || $urandom_range(99) >= 19);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                        m_axis_tdata[111:64], m_axis_tdata[159:112], m_axis_tlast};
                n_results++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp: kind %0d key %h size %h live %h dead %h last %b",
                                     exp_r.kind, exp_r.rkey, exp_r.rsize, exp_r.live,
                                     exp_r.dead, exp_r.last);
                            $display("         got: kind %0d key %h size %h live %h dead %h last %b",
                                     got.kind, got.rkey, got.rsize, got.live,
                                     got.dead, got.last);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !aresetn)
            quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", quiet);
            $display("lru_cache_size_pruning_test: done, errors");
            $finish;
        end
    end

    task automatic apb_write(input int idx, input logic [47:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx * 8); pwdata <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == lcsp_pkg::REG_TOTAL_CAP) cap_total = val; else cap_dead = val;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (2 * NENT + 20) @(posedge aclk);
    endtask

    function automatic void queue_req(logic [1:0] a, logic [31:0] k, logic [31:0] s);
        req_t q;
        q = '{a, k, s};
        pending_reqs = {pending_reqs, q};
    endfunction

    // keys mostly drawn from a small pool so lookups hit and duplicates occur
    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom;
            default: return 32'(($urandom_range(11) * 32'h1111_1111) ^ 32'h0F0F_0F0F);
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(4096);
        endcase
    endfunction

    task automatic random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45) queue_req(lcsp_pkg::ACT_ADD, pick_key(), pick_size());
            else if (r < 85) queue_req(lcsp_pkg::ACT_LOOKUP, pick_key(), $urandom);
            else if (r < 96) queue_req(lcsp_pkg::ACT_PRUNE, $urandom, $urandom);
            else queue_req(ACT_UNUSED, $urandom, $urandom);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        pcount = 0; plive = '0; pdead = '0; cap_total = '0; cap_dead = '0;
        for (int i = 0; i < NENT; i++) begin pk[i] = '0; ps[i] = '0; end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty-list prune, miss, adds at extremes, hits, fill to eviction
        src_calm = 1; sink_calm = 1;
        apb_write(lcsp_pkg::REG_TOTAL_CAP, 48'hFFFF_FFFF_FFFF);
        apb_write(lcsp_pkg::REG_DEAD_CAP, 48'hFFFF_FFFF_FFFF);
        queue_req(lcsp_pkg::ACT_PRUNE, 0, 0);
        queue_req(lcsp_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 0);
        queue_req(lcsp_pkg::ACT_ADD, 32'h0, 32'h0);
        queue_req(lcsp_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(lcsp_pkg::ACT_ADD, 32'h0, 32'h5);
        queue_req(lcsp_pkg::ACT_LOOKUP, 32'h0, 0);
        queue_req(lcsp_pkg::ACT_LOOKUP, 32'h0, 0);
        queue_req(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(lcsp_pkg::ACT_PRUNE, 0, 0);
        drain();
        // full list with receiver holding off so the input stalls
        for (int i = 0; i < NENT + 4; i++)
            queue_req(lcsp_pkg::ACT_ADD, 32'(32'h100 + i), 32'h8000_0000);
        hold_go = 1;
        wait (hold_done);
        drain();
        apb_write(lcsp_pkg::REG_TOTAL_CAP, 48'h0);
        apb_write(lcsp_pkg::REG_DEAD_CAP, 48'h0);
        queue_req(lcsp_pkg::ACT_PRUNE, 0, 0);
        queue_req(lcsp_pkg::ACT_PRUNE, 0, 0);
        drain();

        // random phases across capacity settings
        src_calm = 0; sink_calm = 0;
        for (int ph = 0; ph < 5; ph++) begin
            apb_write(lcsp_pkg::REG_TOTAL_CAP, ph == 4 ? 48'h0 : 48'($urandom_range(200000)));
            apb_write(lcsp_pkg::REG_DEAD_CAP,
                      ph == 3 ? 48'hFFFF_FFFF_FFFF : 48'($urandom_range(9000)));
            if (ph == 2) begin src_calm = 1; sink_calm = 1; end
            else begin src_calm = 0; sink_calm = 0; end
            random_phase(17);
            drain();
        end

        $display("covered %0d result words and %0d prunes, with a full list under a long stall",
                 n_results, n_prunes);
        $display("and capacity limits from zero to full scale");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("lru_cache_size_pruning_test: done, clean");
        else begin
            $display("%0d mismatches, %0d results left", mismatches, expected_results.size());
            $display("lru_cache_size_pruning_test: done, errors");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/lcsp_pkg.sv
sv/lcsp_ram.sv
sv/lru_cache_size_pruning.sv
sv/lcsp_checker.sv
dv/lru_cache_size_pruning_test.sv
